// ----- rtl/rttp_pkg.sv -----
// rttp_pkg: shared types, codes and helpers of the memory-image token parser
// used by every module of the block; depends on nothing
`default_nettype none

package rttp_pkg;

  localparam int ACCUM_W = 64;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [6:0] DWIDTH_RESET = 7'd32;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIX  = 2'd0;
  localparam logic [1:0] CFG_DWIDTH = 2'd1;

  // token kinds
  localparam logic [1:0] TK_ADDR = 2'd0;
  localparam logic [1:0] TK_DATA = 2'd1;
  localparam logic [1:0] TK_END  = 2'd2;
  localparam logic [1:0] TK_ERR  = 2'd3;

  // error codes
  localparam logic [2:0] ERR_SLASH    = 3'd0;
  localparam logic [2:0] ERR_OPEN_CMT = 3'd1;
  localparam logic [2:0] ERR_ADDR_OVF = 3'd2;
  localparam logic [2:0] ERR_ADDR_NIL = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BSTAR,
    MODE_ADDR,
    MODE_DATA,
    MODE_HALT
  } mode_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0]         token_kind;
    logic [ACCUM_W-1:0] load_address;
    logic [ACCUM_W-1:0] data_value;
    logic [ACCUM_W-1:0] unknown_mask;
    logic [2:0]         error_code;
    logic               last_result;
  } res_t;

  // character class of one item, all zero but eof at end of input
  typedef struct packed {
    logic       eof;
    logic       space;
    logic       slash;
    logic       star;
    logic       at;
    logic       newline;
    logic       dat;
    logic       uscore;
    logic       xdig;
    logic       zdig;
    logic       hexok;
    logic [3:0] hval;
  } cls_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [ACCUM_W-1:0] addr,
                                  logic [ACCUM_W-1:0] val, logic [ACCUM_W-1:0] unk,
                                  logic [2:0] err, logic last);
    res_t r;
    r.token_kind   = kind;
    r.load_address = addr;
    r.data_value   = val;
    r.unknown_mask = unk;
    r.error_code   = err;
    r.last_result  = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/readmem_text_token_parser_unit.sv -----
// readmem_text_token_parser_unit: top level of the memory-image text token parser
// depends on rttp_pkg, rttp_front, rttp_queue and rttp_back
//
//   channel | ports                              | direction | payload
//   in      | in_valid, in_ready, in_data        | input     | in_t
//   out     | out_valid, out_ready, out_data     | output    | res_t
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | input   | register index, value
//
// one character item per cycle while the out channel keeps up; an item that ends a
// token and also makes a result of its own yields two result beats in turn
// an accepted item reaches out_valid through a queue slot, then the result register
// rst_n is synchronous; it clears the queue, scanner and result valid flags and
// sets radix_is_hex to 1 and data_width to 32
// a stalled out channel fills the result register, then the queue, then drops in_ready
`default_nettype none

module readmem_text_token_parser_unit import rttp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  logic       radix_r;
  logic [6:0] dwidth_r;
  logic       q_push, q_full, q_pop, q_valid;
  cls_t       push_cls, head_cls;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= 1'b1;
      dwidth_r <= DWIDTH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_RADIX) begin
        radix_r <= cfg_data[0];
      end else if (cfg_index == CFG_DWIDTH) begin
        dwidth_r <= cfg_data;
      end
    end
  end

  rttp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .radix_is_hex (radix_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cls        (push_cls)
  );

  rttp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cls   (push_cls),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cls   (head_cls)
  );

  rttp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .radix_is_hex (radix_r),
    .data_width   (dwidth_r),
    .q_valid      (q_valid),
    .q_cls        (head_cls),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/rttp_front.sv -----
// rttp_front: accepts text items and classifies each character
// depends on rttp_pkg; feeds rttp_queue
`default_nettype none

module rttp_front import rttp_pkg::*; (
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic radix_is_hex,
  input  logic q_full,
  output logic q_push,
  output cls_t q_cls
);

  logic [7:0] c;
  logic       live;
  logic       is_dig, is_lo, is_up, is_x, is_z, is_us;
  logic [3:0] hv;

  assign c    = in_data.in_char;
  assign live = !in_data.end_of_input;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    is_dig = (c >= "0") && (c <= "9");
    is_lo  = (c >= "a") && (c <= "f");
    is_up  = (c >= "A") && (c <= "F");
    is_x   = (c == "x") || (c == "X");
    is_z   = (c == "z") || (c == "Z");
    is_us  = (c == "_");
    if (is_dig) begin
      hv = 4'(c - "0");
    end else if (is_lo) begin
      hv = 4'(c - "a" + 8'd10);
    end else if (is_up) begin
      hv = 4'(c - "A" + 8'd10);
    end else begin
      hv = 4'd0;
    end

    q_cls.eof     = !live;
    q_cls.space   = live && ((c == " ") || (c == 8'h09) || (c == 8'h0a) ||
                             (c == 8'h0d) || (c == 8'h0c) || (c == 8'h0b));
    q_cls.slash   = live && (c == "/");
    q_cls.star    = live && (c == "*");
    q_cls.at      = live && (c == "@");
    q_cls.newline = live && ((c == 8'h0a) || (c == 8'h0d));
    q_cls.uscore  = live && is_us;
    q_cls.xdig    = live && is_x;
    q_cls.zdig    = live && is_z;
    q_cls.hexok   = live && (is_dig || is_lo || is_up);
    q_cls.dat     = live && (is_us || is_x || is_z ||
                             ((is_dig || is_lo || is_up) && (radix_is_hex || hv <= 4'd1)));
    q_cls.hval    = live ? hv : 4'd0;
  end

endmodule

`default_nettype wire

// ----- rtl/rttp_queue.sv -----
// rttp_queue: short queue of classified items between front and back
// depends on rttp_pkg
`default_nettype none

module rttp_queue import rttp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_cls,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cls_t head_cls
);

  cls_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cls   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cls;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rttp_back.sv -----
// rttp_back: token scanner state machine and result staging
// depends on rttp_pkg; takes classified items from rttp_queue
`default_nettype none

module rttp_back import rttp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       radix_is_hex,
  input  logic [6:0] data_width,
  input  logic       q_valid,
  input  cls_t       q_cls,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_data
);

  mode_t              mode_r, mode_nxt;
  logic [ACCUM_W-1:0] acc_r, acc_nxt;
  logic [ACCUM_W-1:0] unk_r, unk_nxt;
  logic               seen_r, seen_nxt;
  logic               out_valid_r, pend_valid_r;
  res_t               out_r, pend_r;

  logic [6:0]         kw;
  logic [ACCUM_W-1:0] mask;
  logic [3:0]         ones, dv, du;
  logic [ACCUM_W-1:0] sh_v, sh_u, sh_v0, sh_u0;
  logic               id_has;
  res_t               id_res;
  mode_t              id_mode;
  res_t               r0, r1;
  logic [1:0]         nres;
  logic               slot_free;

  // kept data width, clamped to 1..ACCUM_W
  always_comb begin
    if (data_width == 7'd0) begin
      kw = 7'd1;
    end else if (data_width > 7'(ACCUM_W)) begin
      kw = 7'(ACCUM_W);
    end else begin
      kw = data_width;
    end
    mask = {ACCUM_W{1'b1}} >> (7'(ACCUM_W) - kw);
  end

  // digit shift of the data accumulators
  always_comb begin
    ones = radix_is_hex ? 4'hf : 4'h1;
    if (q_cls.xdig) begin
      dv = 4'h0;
      du = ones;
    end else if (q_cls.zdig) begin
      dv = ones;
      du = ones;
    end else begin
      dv = q_cls.hval & ones;
      du = 4'h0;
    end
    if (q_cls.uscore) begin
      sh_v  = acc_r;
      sh_u  = unk_r;
      sh_v0 = '0;
      sh_u0 = '0;
    end else begin
      sh_v  = ((radix_is_hex ? (acc_r << 4) : (acc_r << 1)) | ACCUM_W'(dv)) & mask;
      sh_u  = ((radix_is_hex ? (unk_r << 4) : (unk_r << 1)) | ACCUM_W'(du)) & mask;
      sh_v0 = ACCUM_W'(dv) & mask;
      sh_u0 = ACCUM_W'(du) & mask;
    end
  end

  // what a character does between tokens
  always_comb begin
    id_has  = 1'b0;
    id_res  = mk_res(TK_END, '0, '0, '0, ERR_SLASH, 1'b1);
    id_mode = MODE_IDLE;
    if (q_cls.eof) begin
      id_has = 1'b1;
    end else if (q_cls.space) begin
      id_mode = MODE_IDLE;
    end else if (q_cls.slash) begin
      id_mode = MODE_SLASH;
    end else if (q_cls.at) begin
      id_mode = MODE_ADDR;
    end else if (q_cls.dat) begin
      id_mode = MODE_DATA;
    end else begin
      id_has  = 1'b1;
      id_res  = mk_res(TK_ERR, '0, '0, '0, ERR_BAD_CHAR, 1'b1);
      id_mode = MODE_HALT;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    unk_nxt  = unk_r;
    seen_nxt = seen_r;
    r0       = id_res;
    r1       = id_res;
    nres     = 2'd0;
    unique case (mode_r)
      MODE_HALT: begin
        nres = 2'd0;
      end
      MODE_IDLE: begin
        mode_nxt = id_mode;
        nres     = {1'b0, id_has};
        if (q_cls.at) begin
          acc_nxt  = '0;
          seen_nxt = 1'b0;
        end else if (q_cls.dat) begin
          acc_nxt = sh_v0;
          unk_nxt = sh_u0;
        end
      end
      MODE_SLASH: begin
        if (q_cls.slash) begin
          mode_nxt = MODE_LINE;
        end else if (q_cls.star) begin
          mode_nxt = MODE_BLOCK;
        end else begin
          mode_nxt = MODE_HALT;
          r0       = mk_res(TK_ERR, '0, '0, '0, ERR_SLASH, 1'b1);
          nres     = 2'd1;
        end
      end
      MODE_LINE: begin
        if (q_cls.eof) begin
          mode_nxt = MODE_IDLE;
          r0       = mk_res(TK_END, '0, '0, '0, ERR_SLASH, 1'b1);
          nres     = 2'd1;
        end else if (q_cls.newline) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_BLOCK, MODE_BSTAR: begin
        if (q_cls.eof) begin
          mode_nxt = MODE_HALT;
          r0       = mk_res(TK_ERR, '0, '0, '0, ERR_OPEN_CMT, 1'b1);
          nres     = 2'd1;
        end else if (q_cls.star) begin
          mode_nxt = MODE_BSTAR;
        end else if (q_cls.slash && mode_r == MODE_BSTAR) begin
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_BLOCK;
        end
      end
      MODE_ADDR: begin
        if (q_cls.hexok) begin
          if (|acc_r[ACCUM_W-1 -: 4]) begin
            mode_nxt = MODE_HALT;
            r0       = mk_res(TK_ERR, '0, '0, '0, ERR_ADDR_OVF, 1'b1);
            nres     = 2'd1;
          end else begin
            acc_nxt  = (acc_r << 4) | ACCUM_W'(q_cls.hval);
            seen_nxt = 1'b1;
          end
        end else if (!seen_r) begin
          mode_nxt = MODE_HALT;
          r0       = mk_res(TK_ERR, '0, '0, '0, ERR_ADDR_NIL, 1'b1);
          nres     = 2'd1;
        end else begin
          r0       = mk_res(TK_ADDR, acc_r, '0, '0, ERR_SLASH, !id_has);
          nres     = id_has ? 2'd2 : 2'd1;
          mode_nxt = id_mode;
          acc_nxt  = '0;
          seen_nxt = 1'b0;
          if (q_cls.dat) begin
            acc_nxt = sh_v0;
            unk_nxt = sh_u0;
          end
        end
      end
      MODE_DATA: begin
        if (q_cls.dat) begin
          acc_nxt = sh_v;
          unk_nxt = sh_u;
        end else begin
          r0       = mk_res(TK_DATA, '0, acc_r, unk_r, ERR_SLASH, !id_has);
          nres     = id_has ? 2'd2 : 2'd1;
          mode_nxt = id_mode;
          acc_nxt  = '0;
          unk_nxt  = '0;
          seen_nxt = q_cls.at ? 1'b0 : seen_r;
          if (q_cls.dat) begin
            acc_nxt = sh_v0;
            unk_nxt = sh_u0;
          end
        end
      end
      default: begin
        mode_nxt = MODE_HALT;
      end
    endcase
  end

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = q_valid && ((nres == 2'd0) || (!pend_valid_r && slot_free));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      acc_r        <= '0;
      unk_r        <= '0;
      seen_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        unk_r  <= unk_nxt;
        seen_r <= seen_nxt;
      end
      if (slot_free) begin
        if (pend_valid_r) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= 1'b0;
        end else if (q_pop && nres != 2'd0) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= (nres == 2'd2);
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid_r) begin
        out_r <= pend_r;
      end else if (q_pop && nres != 2'd0) begin
        out_r  <= r0;
        pend_r <= r1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rttp_checker.sv -----
// rttp_checker: port-level checks of the token parser, bound to the top level
// depends on rttp_pkg and readmem_text_token_parser_unit
`default_nettype none

module rttp_checker import rttp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input res_t       out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing follows a format error
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.token_kind == TK_ERR |=> !out_valid)
    else $error("result after format error");

  // error code only on error items, and in range
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.token_kind == TK_ERR) ?
      (out_data.error_code <= ERR_BAD_CHAR) : (out_data.error_code == ERR_SLASH))
    else $error("bad error code");

  // value fields only on their own kinds
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.token_kind == TK_DATA || out_data.data_value == '0) &&
      (out_data.token_kind == TK_DATA || out_data.unknown_mask == '0) &&
      (out_data.token_kind == TK_ADDR || out_data.load_address == '0))
    else $error("field set on wrong kind");

  // errors and end of input close an item
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == TK_ERR || out_data.token_kind == TK_END) |->
      out_data.last_result)
    else $error("error or end item not last");

endmodule

bind readmem_text_token_parser_unit rttp_checker u_rttp_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for readmem_text_token_parser_unit, the memory-image text parser
// a queue-fed driver offers text items, a clocked monitor checks tokens against a predictor
// depends on rttp_pkg and readmem_text_token_parser_unit
module tb_top;
  import rttp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready;
  res_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_RADIX;
  logic [6:0] cfg_data = '0;

  readmem_text_token_parser_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // parser prediction state
  mode_t       scan_st = MODE_IDLE;
  logic [63:0] acc_val = '0;
  logic [63:0] acc_unk = '0;
  logic        addr_digit = 1'b0;
  logic        radix_hex = 1'b1;
  logic [6:0]  dwidth = DWIDTH_RESET;
  res_t        step_buf [2];
  int          step_n;

  in_t  char_q [$];
  res_t tok_expect [$];
  int   items_pushed = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   cfg_writes = 0;
  int   err_count = 0;

  int   tx_gap = 0;
  int   tx_burst = 0;
  int   rx_gap = 0;
  int   rx_burst = 0;
  logic rx_ready = 1'b0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  assign out_ready = rx_ready && (hold_left == 0);

  task automatic flag_error(string what);
    if (err_count < 40) $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || (c >= 8'h0a && c <= 8'h0d);
  endfunction

  function automatic bit is_data(logic [7:0] c);
    int h;
    if (c == "_" || c == "x" || c == "X" || c == "z" || c == "Z") return 1'b1;
    h = hex_of(c);
    if (h < 0) return 1'b0;
    return radix_hex ? 1'b1 : (h <= 1);
  endfunction

  function automatic logic [63:0] width_mask(int w);
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  task automatic emit_tok(logic [1:0] kind, logic [63:0] addr, logic [63:0] val,
                          logic [63:0] unk, logic [2:0] err);
    res_t r;
    r.token_kind   = kind;
    r.load_address = addr;
    r.data_value   = val;
    r.unknown_mask = unk;
    r.error_code   = err;
    r.last_result  = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endtask

  task automatic go_halt(logic [2:0] err);
    emit_tok(TK_ERR, '0, '0, '0, err);
    scan_st = MODE_HALT;
  endtask

  task automatic shift_digit(logic [7:0] c);
    int nb;
    int w;
    logic [63:0] m, ones, v, u;
    if (c == "_") return;
    nb = radix_hex ? 4 : 1;
    w = dwidth;
    if (w < 1) w = 1;
    if (w > ACCUM_W) w = ACCUM_W;
    m = width_mask(w);
    ones = width_mask(nb);
    v = '0;
    u = '0;
    if (c == "x" || c == "X") begin
      u = ones;
    end else if (c == "z" || c == "Z") begin
      v = ones;
      u = ones;
    end else begin
      v = hex_of(c);
      v = v & ones;
    end
    acc_val = ((acc_val << nb) | v) & m;
    acc_unk = ((acc_unk << nb) | u) & m;
  endtask

  task automatic start_token(logic [7:0] c, logic eof);
    if (eof) begin
      emit_tok(TK_END, '0, '0, '0, 3'd0);
    end else if (is_ws(c)) begin
      return;
    end else if (c == "/") begin
      scan_st = MODE_SLASH;
    end else if (c == "@") begin
      scan_st = MODE_ADDR;
      acc_val = '0;
      addr_digit = 1'b0;
    end else if (is_data(c)) begin
      scan_st = MODE_DATA;
      acc_val = '0;
      acc_unk = '0;
      shift_digit(c);
    end else begin
      go_halt(ERR_BAD_CHAR);
    end
  endtask

  task automatic scan_char(in_t it);
    logic [7:0]  c;
    logic        eof;
    int          h;
    logic [63:0] d;
    c = it.in_char;
    eof = it.end_of_input;
    step_n = 0;
    case (scan_st)
      MODE_HALT: ;
      MODE_IDLE: start_token(c, eof);
      MODE_SLASH: begin
        if (!eof && c == "/") scan_st = MODE_LINE;
        else if (!eof && c == "*") scan_st = MODE_BLOCK;
        else go_halt(ERR_SLASH);
      end
      MODE_LINE: begin
        if (eof) begin
          scan_st = MODE_IDLE;
          emit_tok(TK_END, '0, '0, '0, 3'd0);
        end else if (c == 8'h0a || c == 8'h0d) begin
          scan_st = MODE_IDLE;
        end
      end
      MODE_BLOCK, MODE_BSTAR: begin
        if (eof) go_halt(ERR_OPEN_CMT);
        else if (c == "*") scan_st = MODE_BSTAR;
        else if (c == "/" && scan_st == MODE_BSTAR) scan_st = MODE_IDLE;
        else scan_st = MODE_BLOCK;
      end
      MODE_ADDR: begin
        h = eof ? -1 : hex_of(c);
        if (h >= 0) begin
          d = h;
          if (acc_val > ((~64'd0 - d) >> 4)) begin
            go_halt(ERR_ADDR_OVF);
          end else begin
            acc_val = (acc_val << 4) + d;
            addr_digit = 1'b1;
          end
        end else if (!addr_digit) begin
          go_halt(ERR_ADDR_NIL);
        end else begin
          emit_tok(TK_ADDR, acc_val, '0, '0, 3'd0);
          scan_st = MODE_IDLE;
          acc_val = '0;
          addr_digit = 1'b0;
          start_token(c, eof);
        end
      end
      default: begin
        if (!eof && is_data(c)) begin
          shift_digit(c);
        end else begin
          emit_tok(TK_DATA, '0, acc_val, acc_unk, 3'd0);
          scan_st = MODE_IDLE;
          acc_val = '0;
          acc_unk = '0;
          start_token(c, eof);
        end
      end
    endcase
    if (step_n > 0) step_buf[step_n-1].last_result = 1'b1;
    for (int i = 0; i < step_n; i++) tok_expect = {tok_expect, step_buf[i]};
  endtask

  always @(posedge clk) begin : drive
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_char(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          in_data <= char_q.pop_front();
          in_valid <= 1'b1;
          if (tx_burst > 0) begin
            tx_burst--;
            tx_gap = 0;
          end else begin
            tx_gap = $urandom_range(0, 6);
            if ($urandom_range(0, 24) == 0) tx_burst = 40;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : collect
    res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (tok_expect.size() == 0) begin
          flag_error($sformatf("token with none expected, kind %0d", out_data.token_kind));
        end else begin
          want = tok_expect.pop_front();
          if (out_data.token_kind !== want.token_kind)
            flag_error($sformatf("token_kind got %0d want %0d",
                                 out_data.token_kind, want.token_kind));
          if (out_data.load_address !== want.load_address)
            flag_error($sformatf("load_address got %h want %h",
                                 out_data.load_address, want.load_address));
          if (out_data.data_value !== want.data_value)
            flag_error($sformatf("data_value got %h want %h",
                                 out_data.data_value, want.data_value));
          if (out_data.unknown_mask !== want.unknown_mask)
            flag_error($sformatf("unknown_mask got %h want %h",
                                 out_data.unknown_mask, want.unknown_mask));
          if (out_data.error_code !== want.error_code)
            flag_error($sformatf("error_code got %0d want %0d",
                                 out_data.error_code, want.error_code));
          if (out_data.last_result !== want.last_result)
            flag_error($sformatf("last_result got %0d want %0d",
                                 out_data.last_result, want.last_result));
        end
        if (rx_burst > 0) begin
          rx_burst--;
          rx_gap = 0;
        end else begin
          rx_gap = $urandom_range(0, 6);
          if ($urandom_range(0, 24) == 0) rx_burst = 30;
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  // long receiver stall so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= 300) begin
      hold_left <= 90;
      hold_done <= 1'b1;
    end
  end

  task automatic put_ch(logic [7:0] c);
    in_t it;
    it.in_char = c;
    it.end_of_input = 1'b0;
    char_q = {char_q, it};
    items_pushed++;
  endtask

  task automatic put_eof();
    in_t it;
    it.in_char = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    char_q = {char_q, it};
    items_pushed++;
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  task automatic put_ws();
    case ($urandom_range(0, 5))
      0: put_ch(8'h20);
      1: put_ch(8'h09);
      2: put_ch(8'h0a);
      3: put_ch(8'h0d);
      4: put_ch(8'h0c);
      default: put_ch(8'h0b);
    endcase
  endtask

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(48 + r);
    if (r < 16) return 8'(87 + r);
    return 8'(49 + r);
  endfunction

  function automatic logic [7:0] data_char();
    case ($urandom_range(0, 15))
      0: return "x";
      1: return "X";
      2: return "z";
      3: return "Z";
      4: return "_";
      default: return radix_hex ? hex_char() : ($urandom_range(0, 1) ? "1" : "0");
    endcase
  endfunction

  // comment body bytes, anything but the given terminators
  task automatic put_body(int n, logic [7:0] no_a, logic [7:0] no_b);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == no_a || c == no_b);
      put_ch(c);
    end
  endtask

  task automatic gen_text(int budget);
    int start, kind, prev, n;
    bit uonly;
    logic [7:0] run [$];
    start = items_pushed;
    prev = 0;
    while (items_pushed - start < budget) begin
      kind = $urandom_range(0, 15);
      if (kind < 3) begin
        put_ws();
        if ($urandom_range(0, 1)) put_ws();
        prev = 0;
      end else if (kind < 7) begin
        if (prev == 1) put_ws();
        put_ch("@");
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_ch("0");
        n = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) repeat (n) put_ch("F");
        else repeat (n) put_ch(hex_char());
        prev = 1;
      end else if (kind < 12) begin
        run.delete();
        uonly = ($urandom_range(0, 11) == 0);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        repeat (n) run = {run, (uonly ? 8'h5f : data_char())};
        if (prev == 2 || (prev == 1 && hex_of(run[0]) >= 0)) put_ws();
        foreach (run[i]) put_ch(run[i]);
        prev = 2;
      end else if (kind < 14) begin
        put_str("//");
        put_body($urandom_range(0, 6), 8'h0a, 8'h0d);
        if ($urandom_range(0, 5) == 0) put_eof();
        else put_ch($urandom_range(0, 1) ? 8'h0a : 8'h0d);
        prev = 0;
      end else if (kind == 14) begin
        put_str("/*");
        put_body($urandom_range(0, 6), "/", "/");
        if ($urandom_range(0, 1)) put_str("*/");
        else put_str("**/");
        prev = 0;
      end else begin
        put_eof();
        prev = 0;
      end
    end
    put_eof();
  endtask

  task automatic settle();
    while (items_taken != items_pushed || tok_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_RADIX) radix_hex = val[0];
    else dwidth = val;
    cfg_writes++;
  endtask

  task automatic set_regs(logic radix, logic [6:0] width);
    write_reg(CFG_RADIX, {6'd0, radix});
    write_reg(CFG_DWIDTH, width);
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stim
    logic [2:0] err_pick;
    logic [7:0] c;
    int w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: comments with extreme bytes, address, x/z data, eof cases
    put_str("/*");
    put_ch(8'h00);
    put_ch(8'hff);
    put_str("**/");
    put_str("@aF\t");
    put_str("1x_Z");
    put_eof();
    put_str("//");
    put_ch(8'h80);
    put_eof();
    put_str("_ ");
    put_eof();
    settle();

    set_regs(1'b0, 7'd1);
    gen_text(80);
    settle();
    set_regs(1'b1, 7'd64);
    gen_text(110);
    settle();
    set_regs(1'b0, 7'd127);
    gen_text(80);
    settle();
    set_regs(1'b1, 7'd0);
    gen_text(80);
    settle();
    set_regs(1'($urandom_range(0, 1)), 7'($urandom_range(1, 64)));
    gen_text(100);
    settle();
    set_regs(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
    gen_text(60);

    // one format error halts the block for the rest of the run
    err_pick = 3'($urandom_range(0, 4));
    case (err_pick)
      ERR_SLASH: begin
        put_ch("/");
        if ($urandom_range(0, 1)) begin
          put_eof();
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c == "/" || c == "*");
          put_ch(c);
        end
      end
      ERR_OPEN_CMT: begin
        put_str("/*");
        put_body($urandom_range(0, 3), "/", "/");
        put_eof();
      end
      ERR_ADDR_OVF: begin
        put_ch("@");
        do c = hex_char(); while (hex_of(c) == 0);
        put_ch(c);
        repeat (16) put_ch(hex_char());
      end
      ERR_ADDR_NIL: begin
        put_ch("@");
        if ($urandom_range(0, 1)) put_eof();
        else put_ws();
      end
      default: begin
        put_ch("1");
        case ($urandom_range(0, 3))
          0: put_ch("#");
          1: put_ch("g");
          2: put_ch(8'($urandom_range(128, 255)));
          default: put_ch(radix_hex ? "G" : "2");
        endcase
      end
    endcase
    repeat (10) begin
      if ($urandom_range(0, 5) == 0) put_eof();
      else put_ch(8'($urandom_range(0, 255)));
    end

    while (items_taken != items_pushed) @(posedge clk);
    for (w = 0; w < 4000 && tok_expect.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tok_expect.size() != 0)
      flag_error($sformatf("%0d tokens never arrived", tok_expect.size()));

    $display("run covered %0d text items and %0d tokens across %0d register writes",
             items_taken, results_seen, cfg_writes);
    $display("halting format error exercised: code %0d", err_pick);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
